// ----- sv/bszc_pkg.sv -----
// bszc_pkg: shared types, codes and constants of the sensorless zero-cross commutator
// no dependencies; compiled first
package bszc_pkg;

    // fixed field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned VOLT_W    = 16;
    localparam int unsigned STEP_W    = 3;
    localparam int unsigned SPEED_W   = 20;
    localparam int unsigned ALPHA_W   = 17;
    localparam int unsigned LIMIT_W   = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;
    localparam int unsigned DIV_NUM_W = 24;
    localparam int unsigned DIV_CNT_W = 5;

    // motor constants
    localparam int unsigned PHASE_COUNT = 3;
    localparam logic [STEP_W-1:0]    STEP_LAST    = 3'd5;
    localparam logic [VOLT_W-1:0]    HYST_MV      = 16'd500;
    localparam logic [DIV_NUM_W-1:0] SPEED_NUM    = 24'd10000000;
    localparam logic [SPEED_W-1:0]   SPEED_MAX    = 20'd1000000;
    localparam logic [TIME_W-1:0]    PERIOD_RESET = 32'd50000;
    localparam logic [ALPHA_W-1:0]   ALPHA_ONE    = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_FORWARD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_LIMIT   = 3'd4;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] THRESH_RESET = 15'd100;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd6554;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd32767;

    // fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OV   = 2'd1;
    localparam logic [1:0] FAULT_OC   = 2'd2;

    // phase indexes
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]        time_us;
        logic signed [VOLT_W-1:0] volt_a;
        logic signed [VOLT_W-1:0] volt_b;
        logic signed [VOLT_W-1:0] volt_c;
        logic signed [VOLT_W-1:0] curr_a;
        logic signed [VOLT_W-1:0] curr_b;
        logic signed [VOLT_W-1:0] curr_c;
    } t_sample;

    typedef struct packed {
        logic [STEP_W-1:0]        step_index;
        logic                     commutated;
        logic [TIME_W-1:0]        period_us;
        logic [SPEED_W-1:0]       speed_rpm;
        logic [1:0]               fault_code;
        logic                     halted;
        logic signed [VOLT_W-1:0] bemf_mv;
    } t_result;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [TIME_W-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    // floating phase for steps 0..5 is C,B,A,C,B,A
    function automatic logic [1:0] open_phase(input logic [STEP_W-1:0] step);
        logic [1:0] ph;
        case (step)
            3'd0, 3'd3: ph = PH_C;
            3'd1, 3'd4: ph = PH_B;
            default:    ph = PH_A;
        endcase
        return ph;
    endfunction

endpackage

// ----- sv/bszc_if.sv -----
// bszc_if: valid/ready channel interfaces for sample sets and results
// depends on bszc_pkg
interface bszc_smp_if;
    logic               valid;
    logic               ready;
    bszc_pkg::t_sample  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bszc_res_if;
    logic               valid;
    logic               ready;
    bszc_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/bszc_div.sv -----
// bszc_div: restoring serial divider, one quotient bit per cycle
// depends on bszc_pkg
module bszc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bszc_pkg::t_div_req i_req,
    output bszc_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [bszc_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [bszc_pkg::TIME_W-1:0]      r_rem;
    logic [bszc_pkg::TIME_W-1:0]      r_den;
    logic [bszc_pkg::DIV_NUM_W-1:0]   r_num;
    logic [bszc_pkg::DIV_NUM_W-1:0]   r_quot;

    logic [bszc_pkg::TIME_W:0]        rem_sh;
    logic [bszc_pkg::TIME_W:0]        rem_sub;
    logic                             fits;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_num[bszc_pkg::DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= bszc_pkg::DIV_CNT_W'(bszc_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bszc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_num  <= i_req.num;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sub[bszc_pkg::TIME_W-1:0] : rem_sh[bszc_pkg::TIME_W-1:0];
            r_num  <= {r_num[bszc_pkg::DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[bszc_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- sv/bldc_sensorless_zero_cross_commutator_top.sv -----
// bldc_sensorless_zero_cross_commutator_top: fault check, bemf filter, crossing detect
// depends on bszc_pkg, bszc_if, bszc_div
// a sample set passes CHECK, MUL and ADD, then DONE loads the output register; when halted
// or faulted it goes from CHECK straight to DONE; a crossing runs the 24-step serial divider
// for speed in DIV; a new sample set is taken only in IDLE, after DONE, which waits on output stall
// reset (synchronous, active low) clears step, polarity, stores, halt and output valid
module bldc_sensorless_zero_cross_commutator_top #(
    parameter int unsigned BLANK_US = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bszc_smp_if.sink                            i_smp,
    bszc_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [bszc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bszc_pkg::CFG_DAT_W-1:0]      i_cfg_wdata
);

    localparam int unsigned VW = bszc_pkg::VOLT_W;

    bszc_pkg::t_state r_state, n_state;

    // configuration
    logic                              r_spin_fwd;
    logic [bszc_pkg::LIMIT_W-1:0]      r_thresh;
    logic [bszc_pkg::ALPHA_W-1:0]      r_alpha;
    logic [bszc_pkg::LIMIT_W-1:0]      r_volt_lim;
    logic [bszc_pkg::LIMIT_W-1:0]      r_curr_lim;

    // motor state
    logic [bszc_pkg::STEP_W-1:0]       r_step;
    logic                              r_falling;
    logic [bszc_pkg::TIME_W-1:0]       r_last_cross;
    logic [bszc_pkg::TIME_W-1:0]       r_period;
    logic [bszc_pkg::SPEED_W-1:0]      r_speed;
    logic signed [VW-1:0]              r_bemf [bszc_pkg::PHASE_COUNT];
    logic                              r_halt;

    // per-item working registers
    bszc_pkg::t_sample                 r_smp;
    logic [1:0]                        r_fault;
    logic                              r_comm;
    logic signed [VW-1:0]              r_bemf_out;
    logic signed [VW:0]                r_diff;
    logic signed [VW+18:0]             r_prod;
    logic [bszc_pkg::TIME_W-1:0]       r_elapsed;

    // output register
    logic                              r_out_valid;
    bszc_pkg::t_result                 r_out;

    // control strobes
    logic                              smp_xfer;
    logic                              res_xfer;
    logic                              load_out;
    logic                              div_start;

    logic [1:0]                        ph;
    logic signed [VW-1:0]              store_ph;
    logic signed [VW-1:0]              volt_ph;
    logic [1:0]                        fault_now;
    logic [bszc_pkg::ALPHA_W-1:0]      alpha_sat;
    logic signed [VW+18:0]             prod_rnd;
    logic signed [VW+2:0]              bemf_sum;
    logic signed [VW-1:0]              bemf_new;
    logic signed [VW+1:0]              lim;
    logic                              crossed;
    logic                              advance;
    logic [bszc_pkg::STEP_W-1:0]       step_next;
    logic signed [VW-1:0]              vlim_s;
    logic signed [VW-1:0]              clim_s;

    bszc_pkg::t_div_req                div_req;
    bszc_pkg::t_div_rsp                div_rsp;

    assign smp_xfer = i_smp.valid && i_smp.ready;
    assign res_xfer = r_out_valid && o_res.ready;

    // floating phase selection
    always_comb begin
        ph       = bszc_pkg::open_phase(r_step);
        store_ph = r_bemf[ph];
        case (ph)
            bszc_pkg::PH_A: volt_ph = r_smp.volt_a;
            bszc_pkg::PH_B: volt_ph = r_smp.volt_b;
            default:        volt_ph = r_smp.volt_c;
        endcase
    end

    // fault scan in A,B,C order, overvoltage before overcurrent
    always_comb begin
        vlim_s = $signed({1'b0, r_volt_lim});
        clim_s = $signed({1'b0, r_curr_lim});
        if (r_smp.volt_a > vlim_s)      fault_now = bszc_pkg::FAULT_OV;
        else if (r_smp.curr_a > clim_s) fault_now = bszc_pkg::FAULT_OC;
        else if (r_smp.volt_b > vlim_s) fault_now = bszc_pkg::FAULT_OV;
        else if (r_smp.curr_b > clim_s) fault_now = bszc_pkg::FAULT_OC;
        else if (r_smp.volt_c > vlim_s) fault_now = bszc_pkg::FAULT_OV;
        else if (r_smp.curr_c > clim_s) fault_now = bszc_pkg::FAULT_OC;
        else                            fault_now = bszc_pkg::FAULT_NONE;
    end

    // filter: s + floor((alpha*(v-s) + 2^15) / 2^16), crossing test on the result
    always_comb begin
        alpha_sat = (r_alpha > bszc_pkg::ALPHA_ONE) ? bszc_pkg::ALPHA_ONE : r_alpha;
        prod_rnd  = r_prod + (VW+19)'(32768);
        bemf_sum  = (VW+3)'(store_ph) + (VW+3)'(prod_rnd >>> 16);
        if (bemf_sum > (VW+3)'(32767))       bemf_new = 16'sh7FFF;
        else if (bemf_sum < -(VW+3)'(32768)) bemf_new = 16'sh8000;
        else                                 bemf_new = bemf_sum[VW-1:0];
        lim     = $signed((VW+2)'(r_thresh) + (VW+2)'(bszc_pkg::HYST_MV));
        crossed = r_falling ? ((VW+2)'(bemf_new) < -lim) : ((VW+2)'(bemf_new) > lim);
        advance = crossed && (r_elapsed >= bszc_pkg::TIME_W'(BLANK_US));
        if (r_spin_fwd)
            step_next = (r_step == bszc_pkg::STEP_LAST) ? '0 : r_step + 1'b1;
        else
            step_next = (r_step == '0) ? bszc_pkg::STEP_LAST : r_step - 1'b1;
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bszc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        div_start = 1'b0;
        case (r_state)
            bszc_pkg::ST_IDLE: begin
                if (smp_xfer) n_state = bszc_pkg::ST_CHECK;
            end
            bszc_pkg::ST_CHECK: begin
                if (r_halt || fault_now != bszc_pkg::FAULT_NONE) n_state = bszc_pkg::ST_DONE;
                else n_state = bszc_pkg::ST_MUL;
            end
            bszc_pkg::ST_MUL: begin
                n_state = bszc_pkg::ST_ADD;
            end
            bszc_pkg::ST_ADD: begin
                if (advance) begin
                    div_start = 1'b1;
                    n_state   = bszc_pkg::ST_DIV;
                end else begin
                    n_state = bszc_pkg::ST_DONE;
                end
            end
            bszc_pkg::ST_DIV: begin
                if (div_rsp.done) n_state = bszc_pkg::ST_DONE;
            end
            bszc_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = bszc_pkg::ST_IDLE;
                end
            end
            default: n_state = bszc_pkg::ST_IDLE;
        endcase
    end

    assign i_smp.ready = (r_state == bszc_pkg::ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_fwd <= 1'b1;
            r_thresh   <= bszc_pkg::THRESH_RESET;
            r_alpha    <= bszc_pkg::ALPHA_RESET;
            r_volt_lim <= bszc_pkg::LIMIT_RESET;
            r_curr_lim <= bszc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bszc_pkg::CFG_SPIN_FORWARD: r_spin_fwd <= i_cfg_wdata[0];
                bszc_pkg::CFG_CROSS_THRESH: r_thresh   <= i_cfg_wdata[bszc_pkg::LIMIT_W-1:0];
                bszc_pkg::CFG_FILTER_ALPHA: r_alpha    <= i_cfg_wdata;
                bszc_pkg::CFG_VOLT_LIMIT:   r_volt_lim <= i_cfg_wdata[bszc_pkg::LIMIT_W-1:0];
                bszc_pkg::CFG_CURR_LIMIT:   r_curr_lim <= i_cfg_wdata[bszc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // motor state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_falling    <= 1'b0;
            r_last_cross <= '0;
            r_period     <= bszc_pkg::PERIOD_RESET;
            r_speed      <= '0;
            r_halt       <= 1'b0;
            for (int i = 0; i < bszc_pkg::PHASE_COUNT; i++) r_bemf[i] <= '0;
        end else begin
            if (r_state == bszc_pkg::ST_CHECK && !r_halt
                && fault_now != bszc_pkg::FAULT_NONE) begin
                r_halt <= 1'b1;
            end
            if (r_state == bszc_pkg::ST_ADD) begin
                r_bemf[ph] <= bemf_new;
                if (advance) begin
                    r_period     <= r_elapsed;
                    r_step       <= step_next;
                    r_last_cross <= r_smp.time_us;
                    r_falling    <= ~r_falling;
                end
            end
            // saturate the divider quotient
            if (r_state == bszc_pkg::ST_DIV && div_rsp.done) begin
                if (div_rsp.quot > bszc_pkg::DIV_NUM_W'(bszc_pkg::SPEED_MAX))
                    r_speed <= bszc_pkg::SPEED_MAX;
                else
                    r_speed <= div_rsp.quot[bszc_pkg::SPEED_W-1:0];
            end
        end
    end

    // per-item datapath registers
    always_ff @(posedge i_clk) begin
        if (smp_xfer) begin
            r_smp <= i_smp.data;
        end
        case (r_state)
            bszc_pkg::ST_CHECK: begin
                r_fault    <= r_halt ? bszc_pkg::FAULT_NONE : fault_now;
                r_comm     <= 1'b0;
                r_bemf_out <= store_ph;
                r_diff     <= (VW+1)'(volt_ph) - (VW+1)'(store_ph);
            end
            bszc_pkg::ST_MUL: begin
                r_prod    <= (VW+19)'($signed({1'b0, alpha_sat})) * (VW+19)'(r_diff);
                r_elapsed <= r_smp.time_us - r_last_cross;
            end
            bszc_pkg::ST_ADD: begin
                r_bemf_out <= bemf_new;
                r_comm     <= advance;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (res_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.step_index <= r_step;
            r_out.commutated <= r_comm;
            r_out.period_us  <= r_period;
            r_out.speed_rpm  <= r_speed;
            r_out.fault_code <= r_fault;
            r_out.halted     <= r_halt;
            r_out.bemf_mv    <= r_bemf_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // speed divider
    assign div_req.start = div_start;
    assign div_req.num   = bszc_pkg::SPEED_NUM;
    assign div_req.den   = r_elapsed;

    bszc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // the halt latch never clears outside reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt latch cleared");

    // a commutation never comes with a halt or a fault
    a_comm_no_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.commutated && (r_out.halted
            || r_out.fault_code != bszc_pkg::FAULT_NONE)))
        else $error("commutation reported together with halt");

    // a fault in a result implies the halt is latched
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault_code != bszc_pkg::FAULT_NONE) |-> r_out.halted)
        else $error("fault without halt");

    // step stays in 0..5
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= bszc_pkg::STEP_LAST)
        else $error("step out of range");

    // divider is started only on the way into the divide state
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == bszc_pkg::ST_DIV))
        else $error("divider started outside divide state");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the sensorless zero-cross commutator top level
// depends on bszc_pkg, bszc_if and the commutator RTL; predicts every result in-bench
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned BLANK_US      = 10;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 40;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bszc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bszc_pkg::CFG_DAT_W-1:0] i_cfg_wdata;

    bszc_smp_if smp_if ();
    bszc_res_if res_if ();

    bldc_sensorless_zero_cross_commutator_top #(
        .BLANK_US (BLANK_US)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow copy of the configuration registers
    logic                         m_fwd;
    logic [bszc_pkg::LIMIT_W-1:0] m_thresh;
    logic [bszc_pkg::ALPHA_W-1:0] m_alpha;
    logic [bszc_pkg::LIMIT_W-1:0] m_vlim;
    logic [bszc_pkg::LIMIT_W-1:0] m_ilim;

    // shadow commutation state
    logic [bszc_pkg::STEP_W-1:0]        m_step;
    logic                               m_falling;
    logic [bszc_pkg::TIME_W-1:0]        m_last_cross;
    logic [bszc_pkg::TIME_W-1:0]        m_period;
    logic [bszc_pkg::SPEED_W-1:0]       m_speed;
    logic signed [bszc_pkg::VOLT_W-1:0] m_bemf [bszc_pkg::PHASE_COUNT];
    logic                               m_halted;

    bszc_pkg::t_sample sample_q [$];
    bszc_pkg::t_result result_q [$];
    bit          smp_taken;
    int          src_gap_left;
    int          snk_gap_left;
    int          hold_left;
    int          hold_req;
    int          hold_seen;
    bit          src_quiet;
    bit          snk_quiet;
    int          fail_cnt;
    int          cycle_cnt;
    logic [31:0] now_us;
    bit          seg_high;

    // idle length: mostly short, a few long, with quiet stretches of none
    function automatic int gap_len(inout bit quiet);
        int r;
        if ($urandom_range(0, 99) == 0) quiet = !quiet;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // q1.16 low pass with round half up
    function automatic logic signed [bszc_pkg::VOLT_W-1:0] lowpass_next(
        input logic signed [bszc_pkg::VOLT_W-1:0] prev,
        input logic signed [bszc_pkg::VOLT_W-1:0] sample
    );
        longint a;
        longint acc;
        a = (m_alpha > bszc_pkg::ALPHA_ONE) ? longint'(bszc_pkg::ALPHA_ONE)
                                            : longint'(m_alpha);
        acc = a * longint'(sample) + (longint'(bszc_pkg::ALPHA_ONE) - a) * longint'(prev)
              + 32768;
        acc = acc >>> 16;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[bszc_pkg::VOLT_W-1:0];
    endfunction

    // expected result of one sample set; advances the shadow state
    function automatic bszc_pkg::t_result predict_commutation(input bszc_pkg::t_sample s);
        bszc_pkg::t_result r;
        int          vv [bszc_pkg::PHASE_COUNT];
        int          ii [bszc_pkg::PHASE_COUNT];
        int          lim;
        int          bv;
        logic [31:0] elapsed;
        logic [1:0]  ph;
        logic [1:0]  fault;
        logic        comm;
        longint      q;
        vv[0] = s.volt_a;
        vv[1] = s.volt_b;
        vv[2] = s.volt_c;
        ii[0] = s.curr_a;
        ii[1] = s.curr_b;
        ii[2] = s.curr_c;
        fault = bszc_pkg::FAULT_NONE;
        comm  = 1'b0;
        ph    = 2'(bszc_pkg::PHASE_COUNT - 1 - m_step % bszc_pkg::PHASE_COUNT);
        if (!m_halted) begin
            // first offending phase wins, voltage before current
            for (int i = 0; i < bszc_pkg::PHASE_COUNT; i++) begin
                if (fault == bszc_pkg::FAULT_NONE) begin
                    if (vv[i] > int'(m_vlim)) fault = bszc_pkg::FAULT_OV;
                    else if (ii[i] > int'(m_ilim)) fault = bszc_pkg::FAULT_OC;
                end
            end
            if (fault != bszc_pkg::FAULT_NONE) begin
                m_halted = 1'b1;
            end else begin
                elapsed    = s.time_us - m_last_cross;
                lim        = int'(m_thresh) + int'(bszc_pkg::HYST_MV);
                m_bemf[ph] = lowpass_next(m_bemf[ph], 16'(vv[ph]));
                bv         = m_bemf[ph];
                if (elapsed >= BLANK_US && (m_falling ? (bv < -lim) : (bv > lim))) begin
                    m_period = elapsed;
                    q = longint'(bszc_pkg::SPEED_NUM) / longint'(elapsed);
                    if (q > longint'(bszc_pkg::SPEED_MAX)) q = bszc_pkg::SPEED_MAX;
                    m_speed = q[bszc_pkg::SPEED_W-1:0];
                    if (m_fwd) m_step = (m_step == bszc_pkg::STEP_LAST) ? '0 : m_step + 1'b1;
                    else m_step = (m_step == '0) ? bszc_pkg::STEP_LAST : m_step - 1'b1;
                    m_last_cross = s.time_us;
                    m_falling    = !m_falling;
                    comm         = 1'b1;
                end
            end
        end
        r.step_index = m_step;
        r.commutated = comm;
        r.period_us  = m_period;
        r.speed_rpm  = m_speed;
        r.fault_code = fault;
        r.halted     = m_halted;
        r.bemf_mv    = m_bemf[ph];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] e,
                                        input logic [31:0] a, input bit sgn);
        if (e !== a) begin
            fail_cnt++;
            if (sgn) $error("%s: expected %0d, got %0d", name, $signed(e), $signed(a));
            else $error("%s: expected %0d, got %0d", name, e, a);
        end
    endfunction

    // random value in [-32768, hi], extremes favored
    function automatic int rand_upto(input int hi);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? hi : -32768;
        return int'($urandom_range(0, hi + 32768)) - 32768;
    endfunction

    // time step: mostly past blanking, some inside it, rare huge jumps and wraps
    function automatic logic [31:0] next_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(0, BLANK_US - 1);
        if (r < 96) return $urandom_range(BLANK_US, 600);
        if (r < 99) return $urandom_range(601, 200000);
        return $urandom;
    endfunction

    task automatic push_sample(input logic [31:0] t, input int va, input int vb,
                               input int vc, input int ia, input int ib, input int ic);
        bszc_pkg::t_sample s;
        s.time_us = t;
        s.volt_a  = 16'(va);
        s.volt_b  = 16'(vb);
        s.volt_c  = 16'(vc);
        s.curr_a  = 16'(ia);
        s.curr_b  = 16'(ib);
        s.curr_c  = 16'(ic);
        sample_q.push_back(s);
    endtask

    // mostly alternating-sign bursts that drive crossings, the rest noise
    task automatic gen_items(input int n);
        int done_n;
        int len;
        int lvl;
        int lim;
        int vmax;
        int v [bszc_pkg::PHASE_COUNT];
        vmax   = m_vlim;
        lim    = int'(m_thresh) + int'(bszc_pkg::HYST_MV);
        done_n = 0;
        while (done_n < n) begin
            if ($urandom_range(0, 4) == 0) begin
                now_us += next_dt();
                push_sample(now_us, rand_upto(vmax), rand_upto(vmax), rand_upto(vmax),
                            rand_upto(m_ilim), rand_upto(m_ilim), rand_upto(m_ilim));
                done_n++;
            end else begin
                // an occasional repeated polarity breaks the sequence
                if ($urandom_range(0, 9) != 0) seg_high = !seg_high;
                if (seg_high) lvl = (lim < vmax) ? int'($urandom_range(lim + 1, vmax)) : vmax;
                else lvl = (lim < 32768) ? -int'($urandom_range(lim + 1, 32768)) : -32768;
                len = $urandom_range(1, 25);
                for (int k = 0; k < len; k++) begin
                    now_us += next_dt();
                    for (int j = 0; j < bszc_pkg::PHASE_COUNT; j++) begin
                        v[j] = lvl + int'($urandom_range(0, 400)) - 200;
                        if (v[j] > vmax) v[j] = vmax;
                        if (v[j] < -32768) v[j] = -32768;
                    end
                    push_sample(now_us, v[0], v[1], v[2],
                                rand_upto(m_ilim), rand_upto(m_ilim), rand_upto(m_ilim));
                    done_n++;
                end
            end
        end
    endtask

    // wait until every queued sample is transferred and every result checked
    task automatic drain();
        while (sample_q.size() != 0 || smp_if.valid || result_q.size() != 0)
            @(posedge i_clk);
    endtask

    // write all five registers on consecutive cycles; block must be idle
    task automatic set_config(input logic fwd, input logic [bszc_pkg::LIMIT_W-1:0] thr,
                              input logic [bszc_pkg::ALPHA_W-1:0] alpha,
                              input logic [bszc_pkg::LIMIT_W-1:0] vlim,
                              input logic [bszc_pkg::LIMIT_W-1:0] ilim);
        logic [bszc_pkg::CFG_IDX_W-1:0] idx [5];
        logic [bszc_pkg::CFG_DAT_W-1:0] val [5];
        idx = '{bszc_pkg::CFG_SPIN_FORWARD, bszc_pkg::CFG_CROSS_THRESH,
                bszc_pkg::CFG_FILTER_ALPHA, bszc_pkg::CFG_VOLT_LIMIT,
                bszc_pkg::CFG_CURR_LIMIT};
        val = '{17'(fwd), 17'(thr), 17'(alpha), 17'(vlim), 17'(ilim)};
        for (int i = 0; i < 5; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= val[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        m_fwd    = fwd;
        m_thresh = thr;
        m_alpha  = alpha;
        m_vlim   = vlim;
        m_ilim   = ilim;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sample driver: holds each item until its transfer, then idles a while
    always @(negedge i_clk) begin : src_drive
        logic nv;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (smp_if.valid && !smp_taken) begin
            nv = 1'b1;
        end else if (src_gap_left > 0) begin
            src_gap_left--;
            nv = 1'b0;
        end else if (sample_q.size() != 0) begin
            smp_if.data  <= sample_q.pop_front();
            nv           = 1'b1;
            src_gap_left = gap_len(src_quiet);
        end else begin
            nv = 1'b0;
        end
        smp_taken = 1'b0;
        smp_if.valid <= nv;
    end

    // result ready: random stalls plus an on-demand long hold-off
    always @(negedge i_clk) begin : snk_drive
        logic nr;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (snk_gap_left > 0) begin
            snk_gap_left--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
            if ($urandom_range(0, 2) == 0) snk_gap_left = gap_len(snk_quiet);
        end
        res_if.ready <= nr;
    end

    // monitor: check result transfers, predict on sample transfers
    always @(posedge i_clk) begin : monitor
        bszc_pkg::t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (result_q.size() == 0) begin
                fail_cnt++;
                $error("result transfer with no prediction waiting");
            end else begin
                exp_r = result_q.pop_front();
                check_field("step_index", 32'(exp_r.step_index),
                            32'(res_if.data.step_index), 1'b0);
                check_field("commutated", 32'(exp_r.commutated),
                            32'(res_if.data.commutated), 1'b0);
                check_field("period_us", exp_r.period_us, res_if.data.period_us, 1'b0);
                check_field("speed_rpm", 32'(exp_r.speed_rpm),
                            32'(res_if.data.speed_rpm), 1'b0);
                check_field("fault_code", 32'(exp_r.fault_code),
                            32'(res_if.data.fault_code), 1'b0);
                check_field("halted", 32'(exp_r.halted), 32'(res_if.data.halted), 1'b0);
                check_field("bemf_mv", 32'(exp_r.bemf_mv),
                            32'(res_if.data.bemf_mv), 1'b1);
            end
        end
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            result_q.push_back(predict_commutation(smp_if.data));
            smp_taken = 1'b1;
        end
    end

    // run time guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int p;
        int v [bszc_pkg::PHASE_COUNT];
        int c [bszc_pkg::PHASE_COUNT];
        logic [1:0] kind;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        res_if.ready = 1'b0;
        fail_cnt     = 0;
        cycle_cnt    = 0;
        hold_req     = 0;
        hold_seen    = 0;
        now_us       = '0;
        m_fwd        = 1'b1;
        m_thresh     = bszc_pkg::THRESH_RESET;
        m_alpha      = bszc_pkg::ALPHA_RESET;
        m_vlim       = bszc_pkg::LIMIT_RESET;
        m_ilim       = bszc_pkg::LIMIT_RESET;
        m_step       = '0;
        m_falling    = 1'b0;
        m_last_cross = '0;
        m_period     = bszc_pkg::PERIOD_RESET;
        m_speed      = '0;
        m_halted     = 1'b0;
        for (int i = 0; i < bszc_pkg::PHASE_COUNT; i++) m_bemf[i] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: blanking, saturated speed, both polarities, wrap, bit patterns
        push_sample(32'd0, 0, 0, 0, 0, 0, 0);
        push_sample(32'd5, 32767, 32767, 32767, 32767, 32767, 32767);
        push_sample(32'd10, 32767, 32767, 32767, 32767, 32767, 32767);
        push_sample(32'd11, -32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(32'd10010, -32768, -32768, -32768, -32768, -32768, -32768);
        push_sample(32'd10011, 32767, 32767, 32767, 0, 0, 0);
        push_sample(32'hFFFF_FFF0, 32767, 32767, 32767, 0, 0, 0);
        push_sample(32'h0000_0020, -32768, -32768, -32768, 0, 0, 0);
        push_sample(32'hAAAA_AAAA, 16'sh5555, 16'sh5555, 16'sh5555, -21846, -21846, -21846);
        push_sample(32'h5555_5555, -21846, -21846, -21846, 16'sh5555, 16'sh5555, 16'sh5555);
        push_sample(32'hFFFF_FFFF, 32767, -1, 32767, -1, 32767, -1);
        push_sample(32'h8000_0000, -1, 32767, -1, 32767, -1, 32767);
        now_us = 32'h8000_0000;
        drain();

        // reverse spin, zero threshold, unity alpha
        set_config(1'b0, 15'd0, bszc_pkg::ALPHA_ONE, 15'd32767, 15'd32767);
        gen_items(220);
        drain();

        // threshold too large to cross, alpha above one
        set_config(1'b1, 15'd32767, 17'd131071, 15'd32767, 15'd32767);
        gen_items(150);
        drain();

        // frozen filter, tight limits
        set_config(1'b0, 15'd1000, 17'd0, 15'd20000, 15'd0);
        gen_items(120);
        drain();

        // minimal alpha, zero voltage limit
        set_config(1'b1, 15'd0, 17'd1, 15'd0, 15'd32767);
        gen_items(80);
        drain();

        // long result hold-off while the sender keeps offering
        set_config(1'b1, 15'd200, 17'd30000, 15'd32767, 15'd32767);
        gen_items(200);
        hold_req++;
        drain();

        // random settings
        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            set_config(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                   : 15'($urandom_range(0, 2000)),
                       ($urandom_range(0, 4) == 0) ? 17'($urandom_range(65537, 131071))
                                                   : 17'($urandom_range(4000, 65536)),
                       ($urandom_range(0, 1) == 0) ? 15'd32767
                                                   : 15'($urandom_range(2000, 32767)),
                       15'($urandom_range(0, 32767)));
            gen_items(250);
            drain();
        end

        // latch a fault, then keep feeding while halted
        set_config(1'($urandom_range(0, 1)), 15'd300, 17'd40000,
                   15'($urandom_range(1000, 30000)), 15'($urandom_range(0, 30000)));
        gen_items(40);
        p    = $urandom_range(0, bszc_pkg::PHASE_COUNT - 1);
        kind = $urandom_range(0, 1) ? bszc_pkg::FAULT_OV : bszc_pkg::FAULT_OC;
        for (int j = 0; j < bszc_pkg::PHASE_COUNT; j++) begin
            v[j] = rand_upto(m_vlim);
            c[j] = rand_upto(m_ilim);
        end
        if (kind == bszc_pkg::FAULT_OV) v[p] = $urandom_range(int'(m_vlim) + 1, 32767);
        else c[p] = $urandom_range(int'(m_ilim) + 1, 32767);
        now_us += next_dt();
        push_sample(now_us, v[0], v[1], v[2], c[0], c[1], c[2]);
        for (int k = 0; k < 10; k++) begin
            now_us += next_dt();
            push_sample(now_us,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768);
        end
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
